// ===== rtl/sfps_pkg.sv =====
// sfps_pkg: shared widths, result kind codes and register map of the frame parser
// no dependencies; compiled first

package sfps_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned KIND_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [KIND_W-1:0] kind_t;

	// result kinds
	localparam kind_t KIND_PAYLOAD = 2'd0;
	localparam kind_t KIND_GOOD    = 2'd1;
	localparam kind_t KIND_BAD     = 2'd2;

	// header bytes
	localparam byte_t HDR_FIRST  = 8'h55;
	localparam byte_t HDR_SECOND = 8'hAA;

	// configuration port
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned REG_IDX_W = 1;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_MAX_DATA_LEN = 1'd0;
	localparam len_t MAX_DATA_LEN_RST = 16'd256;

endpackage

// ===== rtl/sfps_in_if.sv =====
// sfps_in_if: valid/ready channel carrying one received serial byte
// depends on sfps_pkg

interface sfps_in_if import sfps_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sfps_out_if.sv =====
// sfps_out_if: valid/ready channel carrying one parser result
// depends on sfps_pkg

interface sfps_out_if import sfps_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	byte_t payload_byte;
	len_t  byte_index;
	byte_t frame_version;
	byte_t frame_command;
	len_t  frame_length;

	modport source(output valid, output kind, output payload_byte, output byte_index,
		output frame_version, output frame_command, output frame_length, input ready);
	modport sink(input valid, input kind, input payload_byte, input byte_index,
		input frame_version, input frame_command, input frame_length, output ready);
endinterface

// ===== rtl/serial_frame_parser_sum8_unit.sv =====
// serial_frame_parser_sum8_unit: top level of the 55/aa framed byte parser with 8-bit sum
// depends on sfps_pkg, sfps_in_if, sfps_out_if, sfps_apb_regs
//
//  channel   dir  protocol      payload
//  rx        in   valid/ready   rx_byte
//  res       out  valid/ready   kind, payload_byte, byte_index, frame_version,
//                               frame_command, frame_length
//  apb       in   apb-style     max_data_len at byte address 0
//
// one byte per cycle sustained while res drains; a request is registered in the input stage,
// and its result, if any, is registered in the result register that drives res
// the parse step is a single compare/add/update between the input stage and the
// result register, so a new byte is taken every cycle while res keeps draining
// arst_n clears the parser to the header hunt, the sum and counters to zero and
// max_data_len to 256
// a stalled res only holds the input stage when the waiting byte makes a result

module serial_frame_parser_sum8_unit import sfps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	sfps_in_if.sink            rx,
	sfps_out_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_HDR2, PH_VER, PH_CMD, PH_LENHI, PH_LENLO, PH_DATA, PH_SUM
	} phase_t;

	len_t max_data_len;

	sfps_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.max_data_len (max_data_len)
	);

	// input stage
	logic  s1_valid_q;
	byte_t rx_byte_s1;

	// parser state
	phase_t phase_q, phase_d;
	byte_t  sum_q, sum_d;
	len_t   count_q, count_d;
	byte_t  version_q, version_d;
	byte_t  command_q, command_d;
	len_t   length_q, length_d;

	// result register
	logic  out_valid_q;
	kind_t kind_q, kind_d;
	byte_t pbyte_q, pbyte_d;
	len_t  index_q, index_d;

	logic  has_result;
	logic  out_free;
	logic  advance;
	len_t  len_full;
	len_t  count_inc;
	byte_t sum_add;

	// the byte in the input stage makes a result only in the payload and checksum phases
	assign has_result = s1_valid_q && ((phase_q == PH_DATA) || (phase_q == PH_SUM));
	assign out_free   = !out_valid_q || res.ready;
	assign advance    = s1_valid_q && (!has_result || out_free);
	assign rx.ready   = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rx_byte_s1 <= '0;
		end else if (rx.ready) begin
			s1_valid_q <= rx.valid;
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	assign len_full  = {length_q[LEN_W-1:BYTE_W], rx_byte_s1};
	assign count_inc = count_q + len_t'(1);
	assign sum_add   = sum_q + rx_byte_s1;

	// one parse step for the byte in the input stage
	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		count_d   = count_q;
		version_d = version_q;
		command_d = command_q;
		length_d  = length_q;
		kind_d    = KIND_PAYLOAD;
		pbyte_d   = '0;
		index_d   = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte_s1 == HDR_FIRST) begin
					sum_d   = HDR_FIRST;
					phase_d = PH_HDR2;
				end
			end
			PH_HDR2: begin
				// a bad second header byte is not retried as a first one
				if (rx_byte_s1 == HDR_SECOND) begin
					sum_d   = sum_add;
					phase_d = PH_VER;
				end else begin
					phase_d = PH_HUNT;
					sum_d   = '0;
					count_d = '0;
				end
			end
			PH_VER: begin
				version_d = rx_byte_s1;
				sum_d     = sum_add;
				phase_d   = PH_CMD;
			end
			PH_CMD: begin
				command_d = rx_byte_s1;
				sum_d     = sum_add;
				phase_d   = PH_LENHI;
			end
			PH_LENHI: begin
				length_d = {rx_byte_s1, {BYTE_W{1'b0}}};
				sum_d    = sum_add;
				phase_d  = PH_LENLO;
			end
			PH_LENLO: begin
				length_d = len_full;
				count_d  = '0;
				if (len_full > max_data_len) begin
					// oversize frame dropped without a result
					phase_d = PH_HUNT;
					sum_d   = '0;
				end else begin
					sum_d   = sum_add;
					phase_d = (len_full == '0) ? PH_SUM : PH_DATA;
				end
			end
			PH_DATA: begin
				kind_d  = KIND_PAYLOAD;
				pbyte_d = rx_byte_s1;
				index_d = count_q;
				sum_d   = sum_add;
				count_d = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				kind_d  = (rx_byte_s1 == sum_q) ? KIND_GOOD : KIND_BAD;
				phase_d = PH_HUNT;
				sum_d   = '0;
				count_d = '0;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			sum_q       <= '0;
			count_q     <= '0;
			version_q   <= '0;
			command_q   <= '0;
			length_q    <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_PAYLOAD;
			pbyte_q     <= '0;
			index_q     <= '0;
		end else begin
			// a new result refills the register, otherwise a taken one empties it
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q   <= phase_d;
				sum_q     <= sum_d;
				count_q   <= count_d;
				version_q <= version_d;
				command_q <= command_d;
				length_q  <= length_d;
				if (has_result) begin
					kind_q  <= kind_d;
					pbyte_q <= pbyte_d;
					index_q <= index_d;
				end
			end
		end
	end

	// frame fields stay unchanged between a result and the next request that makes one
	logic  held_en;
	byte_t res_version_q;
	byte_t res_command_q;
	len_t  res_length_q;

	assign held_en = advance && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_version_q <= '0;
			res_command_q <= '0;
			res_length_q  <= '0;
		end else if (held_en) begin
			res_version_q <= version_q;
			res_command_q <= command_q;
			res_length_q  <= length_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = kind_q;
	assign res.payload_byte  = pbyte_q;
	assign res.byte_index    = index_q;
	assign res.frame_version = res_version_q;
	assign res.frame_command = res_command_q;
	assign res.frame_length  = res_length_q;

`ifndef SYNTH
	// a byte waiting on a full result register must hold in the input stage
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> (s1_valid_q && $stable(rx_byte_s1)))
		else $error("input stage lost a waiting byte");

	// the payload counter never reaches the declared length while in the payload phase
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (count_q < length_q))
		else $error("payload count overran frame length");

	// payload results carry an index inside the declared length
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.kind == KIND_PAYLOAD)) |-> (res.byte_index < res.frame_length))
		else $error("payload index outside frame");

	// verdicts carry zero payload fields
	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.kind != KIND_PAYLOAD)) |->
		((res.payload_byte == '0) && (res.byte_index == '0)))
		else $error("verdict carries payload data");
`endif

endmodule

// ===== rtl/sfps_apb_regs.sv =====
// sfps_apb_regs: apb-style register file holding the maximum payload length
// depends on sfps_pkg

module sfps_apb_regs import sfps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output len_t               max_data_len
);

	reg_idx_t reg_idx;
	logic     wr_en;
	len_t     max_data_len_q;

	assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_data_len_q <= MAX_DATA_LEN_RST;
		end else if (wr_en && (reg_idx == REG_MAX_DATA_LEN)) begin
			max_data_len_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_MAX_DATA_LEN: prdata = {{(PDATA_W-LEN_W){1'b0}}, max_data_len_q};
			default:          prdata = '0;
		endcase
	end

	assign max_data_len = max_data_len_q;

endmodule

// ===== sim/sfps_result_checker.sv =====
// sfps_result_checker: watches the rx, res and register channels of the frame parser,
// predicts every result and compares it against what the block delivers
// depends on sfps_pkg, sfps_in_if, sfps_out_if

module sfps_result_checker import sfps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	sfps_in_if                 rx,
	sfps_out_if                res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int unsigned        mismatches,
	output int unsigned        expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_MAX = 10;

	typedef enum logic [2:0] {
		PH_HUNT, PH_HDR2, PH_VER, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CSUM
	} phase_e;

	typedef struct packed {
		kind_t kind;
		byte_t payload_byte;
		len_t  byte_index;
		byte_t frame_version;
		byte_t frame_command;
		len_t  frame_length;
	} frame_result_t;

	frame_result_t due_results[$];

	phase_e      phase     = PH_HUNT;
	byte_t       frame_sum = '0;
	len_t        data_seen = '0;
	byte_t       cur_ver   = '0;
	byte_t       cur_cmd   = '0;
	len_t        cur_len   = '0;
	len_t        len_limit = MAX_DATA_LEN_RST;
	int unsigned fail_n    = 0;
	int unsigned due_n     = 0;

	assign mismatches    = fail_n;
	assign expected_left = due_n;

	task automatic back_to_hunt();
		phase     = PH_HUNT;
		frame_sum = '0;
		data_seen = '0;
	endtask

	// advance the frame state by one received byte, queue the result it makes
	task automatic parse_byte(input byte_t b);
		frame_result_t r;
		r.frame_version = cur_ver;
		r.frame_command = cur_cmd;
		r.frame_length  = cur_len;
		case (phase)
			PH_HUNT: begin
				if (b == HDR_FIRST) begin
					frame_sum = HDR_FIRST;
					phase     = PH_HDR2;
				end
			end
			PH_HDR2: begin
				// a wrong second byte is dropped, not retried as a first byte
				if (b == HDR_SECOND) begin
					frame_sum += b;
					phase      = PH_VER;
				end else begin
					back_to_hunt();
				end
			end
			PH_VER: begin
				cur_ver    = b;
				frame_sum += b;
				phase      = PH_CMD;
			end
			PH_CMD: begin
				cur_cmd    = b;
				frame_sum += b;
				phase      = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				cur_len    = {b, 8'h00};
				frame_sum += b;
				phase      = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				cur_len[7:0] = b;
				frame_sum   += b;
				if (cur_len > len_limit) begin
					back_to_hunt();
				end else begin
					data_seen = '0;
					phase     = (cur_len == '0) ? PH_CSUM : PH_DATA;
				end
			end
			PH_DATA: begin
				r.kind         = KIND_PAYLOAD;
				r.payload_byte = b;
				r.byte_index   = data_seen;
				due_results.push_back(r);
				frame_sum += b;
				data_seen += 1'b1;
				if (data_seen >= cur_len)
					phase = PH_CSUM;
			end
			default: begin
				r.kind         = (b == frame_sum) ? KIND_GOOD : KIND_BAD;
				r.payload_byte = '0;
				r.byte_index   = '0;
				due_results.push_back(r);
				back_to_hunt();
			end
		endcase
	endtask

	task automatic check_result();
		frame_result_t got;
		frame_result_t want;
		got = {res.kind, res.payload_byte, res.byte_index, res.frame_version,
			res.frame_command, res.frame_length};
		if (due_results.size() == 0) begin
			fail_n++;
			if (fail_n <= REPORT_MAX)
				$display("%0t: result with nothing expected: kind %0d byte %h idx %0d",
					$time, got.kind, got.payload_byte, got.byte_index);
		end else begin
			want = due_results.pop_front();
			if (got !== want) begin
				fail_n++;
				if (fail_n <= REPORT_MAX)
					$display({"%0t: mismatch exp kind %0d byte %h idx %0d ver %h cmd %h len %0d",
						" / got kind %0d byte %h idx %0d ver %h cmd %h len %0d"}, $time,
						want.kind, want.payload_byte, want.byte_index, want.frame_version,
						want.frame_command, want.frame_length,
						got.kind, got.payload_byte, got.byte_index, got.frame_version,
						got.frame_command, got.frame_length);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_to_hunt();
			cur_ver   = '0;
			cur_cmd   = '0;
			cur_len   = '0;
			len_limit = MAX_DATA_LEN_RST;
			due_results.delete();
		end else begin
			if (psel && penable && pwrite && pready
				&& reg_idx_t'(paddr >> 2) == REG_MAX_DATA_LEN)
				len_limit = pwdata[LEN_W-1:0];
			if (rx.valid && rx.ready)
				parse_byte(rx.rx_byte);
			if (res.valid && res.ready)
				check_result();
		end
		due_n = due_results.size();
	end

endmodule

// ===== sim/tb_serial_frame_parser_sum8_unit.sv =====
// tb_serial_frame_parser_sum8_unit: stimulus and verdict for the 55/aa frame parser
// depends on sfps_pkg, sfps_in_if, sfps_out_if, sfps_result_checker and the parser rtl

module tb_serial_frame_parser_sum8_unit;
	import sfps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLK_PERIOD   = 12;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned LIMIT_CYCLES = 200000;
	// margin for the input stage and result register to empty, for bytes that make no result
	localparam int unsigned IDLE_SETTLE  = 4;
	localparam int unsigned LONG_HOLD    = 300;
	// unused register index, writes there must change nothing
	localparam reg_idx_t REG_SPARE = 1'd1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned mismatches;
	int unsigned expected_left;
	int unsigned cycle_count = 0;

	// stimulus knobs shared between the sender and receiver processes
	bit   rx_gaps     = 1'b1;
	bit   res_gaps    = 1'b1;
	bit   hold_req    = 1'b0;
	int   hold_cycles = 0;
	len_t max_len_set = MAX_DATA_LEN_RST;
	int   frame_bytes = 0;

	sfps_in_if  rx();
	sfps_out_if res();

	serial_frame_parser_sum8_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sfps_result_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx),
		.res           (res),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall before each result, plus a long hold-off on request
	initial begin
		int gap;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// counted here so the sender keeps pushing and the parser backs up
				res.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = res_gaps ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	function automatic byte_t sum8(input byte_t q[$]);
		byte_t s;
		s = '0;
		foreach (q[i]) s += q[i];
		return s;
	endfunction

	// one rx request; valid stays high between back-to-back requests
	task automatic send_byte(input byte_t b);
		int gap;
		gap = rx_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
	endtask

	task automatic send_bytes(input byte_t q[$]);
		foreach (q[i]) send_byte(q[i]);
		frame_bytes += q.size();
	endtask

	// full frame with random payload; a length over the limit stops after the length bytes
	task automatic send_frame(input byte_t ver, input byte_t cmd, input len_t len,
		input bit bad_sum);
		byte_t q[$];
		byte_t s;
		q = '{HDR_FIRST, HDR_SECOND, ver, cmd, len[15:8], len[7:0]};
		if (len <= max_len_set) begin
			for (int i = 0; i < len; i++)
				q.push_back(byte_t'($urandom));
			s = sum8(q);
			if (bad_sum)
				s += byte_t'($urandom_range(1, 255));
			q.push_back(s);
		end
		send_bytes(q);
	endtask

	// stop offering, let every expected result drain, then let the pipe empty
	task automatic wait_idle();
		rx.valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// new length limit, with junk in the unused upper data bits
	task automatic set_max_len(input len_t v);
		wait_idle();
		apb_write({REG_MAX_DATA_LEN, 2'b00}, {16'($urandom), v});
		max_len_set = v;
	endtask

	// mostly well-formed frames with random content, the rest noise and broken headers
	task automatic random_traffic(input int target);
		int    start;
		int    pick;
		int    top_len;
		len_t  len;
		byte_t b;
		start = frame_bytes;
		while (frame_bytes - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				top_len = (max_len_set < 12) ? max_len_set : 12;
				if ($urandom_range(0, 9) == 0 && max_len_set != 16'hFFFF)
					len = $urandom_range(0, 1) ? len_t'(max_len_set + 1)
						: len_t'($urandom_range(max_len_set + 1, 16'hFFFF));
				else
					len = len_t'($urandom_range(0, top_len));
				send_frame(byte_t'($urandom), byte_t'($urandom), len,
					$urandom_range(0, 3) == 0);
			end else if (pick < 80) begin
				// idle-line noise, never a first header byte so frames stay in sync
				repeat ($urandom_range(1, 4)) begin
					b = byte_t'($urandom);
					if (b == HDR_FIRST)
						b = ~b;
					send_byte(b);
				end
			end else if (pick < 90) begin
				b = byte_t'($urandom);
				if (b == HDR_SECOND)
					b = HDR_FIRST;
				send_bytes('{HDR_FIRST, b});
			end else if (pick < 95 && max_len_set <= MAX_DATA_LEN_RST) begin
				// header cut short; the next header lands in the length and gets dropped
				send_bytes('{HDR_FIRST, HDR_SECOND, byte_t'($urandom), byte_t'($urandom)});
			end else begin
				send_bytes('{HDR_FIRST, HDR_FIRST, HDR_SECOND});
			end
		end
	endtask

	initial begin
		byte_t q[$];
		rx.valid   <= 1'b0;
		rx.rx_byte <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		arst_n     <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme version/command, payload 00 and ff, good checksum
		q = '{HDR_FIRST, HDR_SECOND, 8'hFF, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF};
		q.push_back(sum8(q));
		send_bytes(q);
		// zero length goes straight to the checksum, here a bad one
		q = '{HDR_FIRST, HDR_SECOND, 8'h00, 8'hFF, 8'h00, 8'h00};
		q.push_back(sum8(q) + 8'h01);
		send_bytes(q);
		// bad second header that is itself a first header byte, then a stray second byte
		send_bytes('{HDR_FIRST, HDR_FIRST, HDR_SECOND});
		// length far above the reset limit, dropped without a result
		send_bytes('{HDR_FIRST, HDR_SECOND, 8'h00, 8'hFF, 8'hFF, 8'hFF});

		// reset limit, idling on both sides
		random_traffic(250);

		// limit zero: only empty frames pass, sender runs flat out
		set_max_len(16'h0000);
		rx_gaps = 1'b0;
		random_traffic(80);

		// widest limit, no idling on either side
		set_max_len(16'hFFFF);
		res_gaps = 1'b0;
		random_traffic(100);
		// long receiver hold-off while a long frame keeps coming
		hold_cycles = LONG_HOLD;
		hold_req    = 1'b1;
		send_frame(byte_t'($urandom), byte_t'($urandom), 16'd60, 1'b0);
		random_traffic(50);

		// small limit, receiver never stalls
		set_max_len(16'd5);
		rx_gaps = 1'b1;
		random_traffic(150);
		// header taken under one limit, length checked under the next
		q = '{HDR_FIRST, HDR_SECOND, byte_t'($urandom), byte_t'($urandom), 8'h00, 8'd10};
		repeat (10) q.push_back(byte_t'($urandom));
		q.push_back(sum8(q));
		send_bytes(q[0:3]);
		set_max_len(16'd20);
		send_bytes(q[4:$]);

		// write to the unused register must leave the limit alone
		wait_idle();
		apb_write({REG_SPARE, 2'b00}, $urandom);
		res_gaps = 1'b1;
		random_traffic(120);

		wait_idle();
		repeat (2 * IDLE_SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_left == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
